>>> rtl/assert_macros.svh
// Assertion macros shared by the route table RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define LPM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/lpm_pkg.sv
// Shared types and codes for the longest-prefix-match route table.
// No dependencies.
`default_nettype none

package lpm_pkg;

    // Width of the bit_count and matched_length fields
    localparam int LEN_W = 6;
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_INS_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_HIT    = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS   = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Control part of the token that walks the cell chain.
    // done: insert has landed, or lookup has found at least one match.
    typedef struct packed {
        logic vld;
        logic kind;
        logic done;
    } lpm_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lpm_if.sv
// Valid/ready channel interfaces for the route table request and response.
// Depends on lpm_pkg for field widths.
`default_nettype none

interface lpm_req_if
    import lpm_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int ROUTER_BITS  = 16
);
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [ADDRESS_BITS-1:0] addr_bits;
    logic [LEN_W-1:0]        bit_count;
    logic [ROUTER_BITS-1:0]  router_id;

    modport source (output valid, kind, addr_bits, bit_count, router_id, input ready);
    modport sink   (input valid, kind, addr_bits, bit_count, router_id, output ready);
endinterface

interface lpm_rsp_if
    import lpm_pkg::*;
#(
    parameter int ROUTER_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [ST_W-1:0]        status;
    logic [ROUTER_BITS-1:0] matched_router;
    logic [LEN_W-1:0]       matched_length;

    modport source (output valid, status, matched_router, matched_length, input ready);
    modport sink   (input valid, status, matched_router, matched_length, output ready);
endinterface

`default_nettype wire

>>> rtl/lpm_cell.sv
// One route table entry plus one stage of the token chain.
// Depends on lpm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lpm_cell
    import lpm_pkg::*;
#(
    parameter int AW = 32,
    parameter int RW = 16,
    parameter int LW = 6
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lpm_ctl_t      ctl_i,
    input  wire logic [AW-1:0] addr_i,
    input  wire logic [LW-1:0] len_i,
    input  wire logic [RW-1:0] rtr_i,
    input  wire logic [LW-1:0] blen_i,
    output lpm_ctl_t           ctl_o,
    output logic [AW-1:0]      addr_o,
    output logic [LW-1:0]      len_o,
    output logic [RW-1:0]      rtr_o,
    output logic [LW-1:0]      blen_o
);

    logic          valid_reg;
    logic          valid_next;
    logic [AW-1:0] prefix_reg;
    logic [AW-1:0] prefix_next;
    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;
    logic [RW-1:0] router_reg;
    logic [RW-1:0] router_next;

    lpm_ctl_t      ctl_reg;
    lpm_ctl_t      ctl_next;
    logic [AW-1:0] addr_reg;
    logic [LW-1:0] len_reg;
    logic [RW-1:0] rtr_reg;
    logic [RW-1:0] rtr_next;
    logic [LW-1:0] blen_reg;
    logic [LW-1:0] blen_next;

    logic          is_ins;
    logic          is_lkp;
    logic          exact;
    logic          match;
    logic [AW-1:0] entry_mask;

    assign is_ins     = ctl_i.vld && (ctl_i.kind == KIND_INSERT);
    assign is_lkp     = ctl_i.vld && (ctl_i.kind == KIND_LOOKUP);
    assign entry_mask = ~({AW{1'b1}} >> length_reg);
    assign exact      = valid_reg && (length_reg == len_i) && (prefix_reg == addr_i);
    assign match      = valid_reg && (length_reg <= len_i)
                        && ((addr_i & entry_mask) == prefix_reg);

    always_comb
    begin
        valid_next  = valid_reg;
        prefix_next = prefix_reg;
        length_next = length_reg;
        router_next = router_reg;
        ctl_next    = ctl_i;
        rtr_next    = rtr_i;
        blen_next   = blen_i;
        if (is_ins && !ctl_i.done)
        begin
            // cells fill in order, so the first free cell means no exact match exists
            if (exact)
            begin
                router_next   = rtr_i;
                ctl_next.done = 1'b1;
            end
            else if (!valid_reg)
            begin
                valid_next    = 1'b1;
                prefix_next   = addr_i;
                length_next   = len_i;
                router_next   = rtr_i;
                ctl_next.done = 1'b1;
            end
        end
        if (is_lkp && match && (!ctl_i.done || (length_reg > blen_i)))
        begin
            ctl_next.done = 1'b1;
            rtr_next      = router_reg;
            blen_next     = length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        length_reg <= length_next;
        router_reg <= router_next;
        addr_reg   <= addr_i;
        len_reg    <= len_i;
        rtr_reg    <= rtr_next;
        blen_reg   <= blen_next;
    end

    assign ctl_o  = ctl_reg;
    assign addr_o = addr_reg;
    assign len_o  = len_reg;
    assign rtr_o  = rtr_reg;
    assign blen_o = blen_reg;

    `LPM_NEVER(a_entry_kept, $fell(valid_reg), "route entry lost its valid bit")
    `LPM_ASSERT(a_lookup_no_write, is_lkp |=> $stable(valid_reg), "lookup claimed an entry")
    `LPM_ASSERT(a_done_sticks, (ctl_i.vld && ctl_i.done) |=> ctl_reg.done, "token lost done")

endmodule

`default_nettype wire

>>> rtl/longest_prefix_match_table.sv
// A request token passes through the register of each entry cell in turn, then the response register.
// One token walks the chain of entry cells, one cell per cycle.
// One item at a time: a new request is taken the cycle after the response beat.
// Reset clears all entry valid bits at once; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int ADDRESS_BITS  = 32,
    parameter int ROUTER_BITS   = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpm_req_if.sink    req,
    lpm_rsp_if.source  rsp
);

    localparam int LW = ($clog2(ADDRESS_BITS + 1) > LEN_W) ? $clog2(ADDRESS_BITS + 1) : LEN_W;

    lpm_ctl_t                ctl_c  [0:TABLE_ENTRIES];
    logic [ADDRESS_BITS-1:0] addr_c [0:TABLE_ENTRIES];
    logic [LW-1:0]           len_c  [0:TABLE_ENTRIES];
    logic [ROUTER_BITS-1:0]  rtr_c  [0:TABLE_ENTRIES];
    logic [LW-1:0]           blen_c [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] tok_vld;

    logic                    busy_reg;
    logic                    busy_next;
    logic                    rsp_vld_reg;
    logic                    rsp_vld_next;
    logic [ST_W-1:0]         status_reg;
    logic [ST_W-1:0]         status_next;
    logic [ROUTER_BITS-1:0]  mrtr_reg;
    logic [ROUTER_BITS-1:0]  mrtr_next;
    logic [LEN_W-1:0]        mlen_reg;
    logic [LEN_W-1:0]        mlen_next;

    logic                    accept;
    logic                    rsp_take;
    logic [LW-1:0]           len_in;
    logic [ADDRESS_BITS-1:0] mask_in;
    lpm_ctl_t                tail;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && req.ready;
    assign rsp_take  = rsp.valid && rsp.ready;

    // Saturate the length, then drop address bits past it
    assign len_in  = (LW'(req.bit_count) > LW'(ADDRESS_BITS)) ? LW'(ADDRESS_BITS)
                                                               : LW'(req.bit_count);
    assign mask_in = ~({ADDRESS_BITS{1'b1}} >> len_in);

    // vld, kind, done
    assign ctl_c[0]  = {accept, req.kind, 1'b0};
    assign addr_c[0] = req.addr_bits & mask_in;
    assign len_c[0]  = len_in;
    assign rtr_c[0]  = req.router_id;
    assign blen_c[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lpm_cell #(
            .AW (ADDRESS_BITS),
            .RW (ROUTER_BITS),
            .LW (LW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl_i  (ctl_c[i]),
            .addr_i (addr_c[i]),
            .len_i  (len_c[i]),
            .rtr_i  (rtr_c[i]),
            .blen_i (blen_c[i]),
            .ctl_o  (ctl_c[i+1]),
            .addr_o (addr_c[i+1]),
            .len_o  (len_c[i+1]),
            .rtr_o  (rtr_c[i+1]),
            .blen_o (blen_c[i+1])
        );
        assign tok_vld[i] = ctl_c[i+1].vld;
    end

    assign tail = ctl_c[TABLE_ENTRIES];

    always_comb
    begin
        busy_next    = busy_reg;
        rsp_vld_next = rsp_vld_reg;
        if (accept)
            busy_next = 1'b1;
        else if (rsp_take)
            busy_next = 1'b0;
        if (tail.vld)
            rsp_vld_next = 1'b1;
        else if (rsp_take)
            rsp_vld_next = 1'b0;
    end

    always_comb
    begin
        status_next = status_reg;
        mrtr_next   = mrtr_reg;
        mlen_next   = mlen_reg;
        if (tail.vld)
        begin
            mrtr_next = '0;
            mlen_next = '0;
            if (tail.kind == KIND_INSERT)
                status_next = tail.done ? ST_INS_OK : ST_FULL;
            else if (tail.done)
            begin
                status_next = ST_HIT;
                mrtr_next   = rtr_c[TABLE_ENTRIES];
                mlen_next   = LEN_W'(blen_c[TABLE_ENTRIES]);
            end
            else
                status_next = ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        mrtr_reg   <= mrtr_next;
        mlen_reg   <= mlen_next;
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.status         = status_reg;
    assign rsp.matched_router = mrtr_reg;
    assign rsp.matched_length = mlen_reg;

    `LPM_ASSERT(a_one_token, $onehot0(tok_vld), "more than one token in the chain")
    `LPM_ASSERT(a_rsp_while_busy, rsp_vld_reg |-> busy_reg, "response beat with no item open")
    `LPM_ASSERT(a_launch, accept |=> (tok_vld[0] && !req.ready), "accepted beat not launched")

endmodule

`default_nettype wire

>>> dv/lpm_table_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the longest-prefix-match route table: watches the request and
// response channels, predicts each response and compares. Depends on lpm_pkg, lpm_if.

module lpm_table_checker
    import lpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int ADDRESS_BITS  = 32,
    parameter int ROUTER_BITS   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    lpm_req_if   req,
    lpm_rsp_if   rsp,
    output int   mismatches,
    output int   pending,
    output int   hit_total,
    output int   miss_total,
    output int   full_total
);

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [ROUTER_BITS-1:0] router;
        logic [LEN_W-1:0]       length;
    } route_result_t;

    logic [ADDRESS_BITS-1:0] route_prefix [TABLE_ENTRIES];
    logic [LEN_W-1:0]        route_len    [TABLE_ENTRIES];
    logic [ROUTER_BITS-1:0]  route_router [TABLE_ENTRIES];
    int                      route_used;
    route_result_t           route_results_q [$];
    route_result_t           want;
    route_result_t           got;

    function automatic logic [ADDRESS_BITS-1:0] lead_bits(logic [LEN_W-1:0] len);
        logic [ADDRESS_BITS-1:0] ones;
        ones = '1;
        if (len == 0)
            return '0;
        return ones << (ADDRESS_BITS - len);
    endfunction

    // Applies one request to the shadow table and returns the response it causes.
    function automatic route_result_t route_step(logic kind, logic [ADDRESS_BITS-1:0] addr,
                                                 logic [LEN_W-1:0] cnt,
                                                 logic [ROUTER_BITS-1:0] rid);
        route_result_t           res;
        logic [LEN_W-1:0]        len;
        logic [ADDRESS_BITS-1:0] key;
        int                      slot;
        logic                    found;
        res   = '0;
        found = 1'b0;
        slot  = -1;
        len   = (cnt > ADDRESS_BITS) ? LEN_W'(ADDRESS_BITS) : cnt;
        key   = addr & lead_bits(len);
        if (kind == KIND_INSERT)
        begin
            for (int i = 0; i < route_used; i++)
                if (slot < 0 && route_len[i] == len && route_prefix[i] == key)
                    slot = i;
            if (slot < 0 && route_used < TABLE_ENTRIES)
            begin
                slot               = route_used;
                route_used++;
                route_prefix[slot] = key;
                route_len[slot]    = len;
            end
            if (slot < 0)
                res.status = ST_FULL;
            else
            begin
                route_router[slot] = rid;
                res.status         = ST_INS_OK;
            end
        end
        else
        begin
            // a prefix longer than the address can never match
            for (int i = 0; i < route_used; i++)
                if (route_len[i] <= len && (key & lead_bits(route_len[i])) == route_prefix[i]
                    && (!found || route_len[i] > res.length))
                begin
                    found      = 1'b1;
                    res.length = route_len[i];
                    res.router = route_router[i];
                end
            res.status = found ? ST_HIT : ST_MISS;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_used = 0;
            route_results_q.delete();
            pending    = 0;
        end
        else
        begin
            // response first: a request taken on this edge cannot be answered on it
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.matched_router, rsp.matched_length};
                if (route_results_q.size() == 0)
                begin
                    $display("%0t: response beat with nothing outstanding, got %0d/%h/%0d",
                             $time, got.status, got.router, got.length);
                    mismatches++;
                end
                else
                begin
                    want = route_results_q.pop_front();
                    if (got.status != want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.router != want.router)
                    begin
                        $display("%0t: matched_router expected %h actual %h",
                                 $time, want.router, got.router);
                        mismatches++;
                    end
                    if (got.length != want.length)
                    begin
                        $display("%0t: matched_length expected %0d actual %0d",
                                 $time, want.length, got.length);
                        mismatches++;
                    end
                    case (want.status)
                        ST_HIT:  hit_total++;
                        ST_MISS: miss_total++;
                        ST_FULL: full_total++;
                        default: ;
                    endcase
                end
            end
            if (req.valid && req.ready)
                route_results_q.push_back(route_step(req.kind, req.addr_bits, req.bit_count,
                                                     req.router_id));
            pending = route_results_q.size();
        end
    end

endmodule

>>> dv/longest_prefix_match_table_tb.sv
`timescale 1ns / 100ps
// Top of the route table testbench: clock, reset, request and response traffic
// and the verdict. Depends on lpm_pkg, lpm_if, the route table and lpm_table_checker.

module longest_prefix_match_table_tb;
    import lpm_pkg::*;

    localparam int TABLE_ENTRIES    = 256;
    localparam int ADDR_W           = 32;
    localparam int ROUTER_W         = 16;
    localparam int RANDOM_ITEMS     = 480;
    localparam int FILL_ITEMS       = 360;
    localparam int DRAIN_CYCLES     = TABLE_ENTRIES + 8;
    localparam int HOLD_CYCLES      = 3000;
    localparam int HOLD_AFTER_BEATS = 120;
    localparam int CYCLE_LIMIT      = 1_000_000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } prefix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    lpm_req_if #(.ADDRESS_BITS(ADDR_W), .ROUTER_BITS(ROUTER_W)) req_ch ();
    lpm_rsp_if #(.ROUTER_BITS(ROUTER_W))                        rsp_ch ();

    int mismatches;
    int pending;
    int hit_total;
    int miss_total;
    int full_total;

    longest_prefix_match_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDRESS_BITS (ADDR_W),
        .ROUTER_BITS  (ROUTER_W)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    lpm_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDRESS_BITS (ADDR_W),
        .ROUTER_BITS  (ROUTER_W)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .mismatches(mismatches),
        .pending   (pending),
        .hit_total (hit_total),
        .miss_total(miss_total),
        .full_total(full_total)
    );

    prefix_t prefix_pool [$];
    int      burst_left;
    int      insert_items;
    int      lookup_items;
    int      cycles;

    // Leaves valid high after the beat so back-to-back items need no re-raise.
    task automatic send_item(logic kind, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] cnt,
                             logic [ROUTER_W-1:0] rid);
        int      gap;
        int      r;
        prefix_t pf;
        if (burst_left == 0)
        begin
            r   = $urandom_range(0, 99);
            gap = r < 40 ? 0 : r < 75 ? $urandom_range(1, 4) :
                  r < 93 ? $urandom_range(5, 40) : $urandom_range(100, 260);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.addr_bits <= addr;
        req_ch.bit_count <= cnt;
        req_ch.router_id <= rid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == KIND_INSERT)
        begin
            insert_items++;
            pf.addr = addr;
            pf.len  = (cnt > ADDR_W) ? LEN_W'(ADDR_W) : cnt;
            prefix_pool.push_back(pf);
        end
        else
            lookup_items++;
    endtask

    // One insert in five and six lookups in ten reuse a known prefix: overwrites, and lookups that walk down to it.
    task automatic send_random(bit fill_phase);
        prefix_t           pf;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  cnt;
        int                r;
        r = $urandom_range(0, 99);
        if (r < (fill_phase ? 80 : 35))
        begin
            if (prefix_pool.size() != 0 && $urandom_range(0, 4) == 0)
            begin
                pf   = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
                addr = pf.addr ^ ($urandom >> pf.len);
                cnt  = (pf.len == ADDR_W && $urandom_range(0, 1) == 1) ?
                       LEN_W'($urandom_range(33, 63)) : pf.len;
            end
            else
            begin
                addr = $urandom;
                r    = $urandom_range(0, 99);
                cnt  = r < 85 ? LEN_W'($urandom_range(8, 32)) :
                       r < 95 ? LEN_W'($urandom_range(0, 7)) : LEN_W'($urandom_range(33, 63));
            end
            send_item(KIND_INSERT, addr, cnt, ROUTER_W'($urandom));
        end
        else
        begin
            if (prefix_pool.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                pf   = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
                addr = pf.addr ^ ($urandom >> pf.len);
                cnt  = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, pf.len)) :
                       LEN_W'($urandom_range(pf.len, 63));
            end
            else
            begin
                addr = $urandom;
                cnt  = LEN_W'($urandom_range(0, 63));
            end
            send_item(KIND_LOOKUP, addr, cnt, ROUTER_W'($urandom));
        end
    endtask

    initial
    begin
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_INSERT;
        req_ch.addr_bits <= '0;
        req_ch.bit_count <= '0;
        req_ch.router_id <= '0;
        burst_left   = 0;
        insert_items = 0;
        lookup_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing can match
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0000);
        send_item(KIND_INSERT, 32'hC0A8_0000, 6'd16, 16'h1111);
        send_item(KIND_INSERT, 32'hC0A8_0100, 6'd24, 16'h2222);
        send_item(KIND_LOOKUP, 32'hC0A8_0155, 6'd32, 16'hFFFF);
        // address shorter than the /24: falls back to the /16
        send_item(KIND_LOOKUP, 32'hC0A8_0155, 6'd20, 16'h0000);
        send_item(KIND_LOOKUP, 32'hC0A9_0000, 6'd32, 16'h0000);
        // default route; bits past the length are ignored
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
        send_item(KIND_LOOKUP, 32'h1234_5678, 6'd32, 16'h0000);
        send_item(KIND_LOOKUP, 32'hC0A8_0100, 6'd0, 16'h0000);
        // overwrite of the /16 with junk in the trailing bits
        send_item(KIND_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h0000);
        send_item(KIND_LOOKUP, 32'hC0A8_7777, 6'd32, 16'h0000);
        // lengths past the address width saturate
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hABCD);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd40, 16'h0000);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h5555);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd33, 16'h0000);
        send_item(KIND_INSERT, 32'h0000_0000, 6'd32, 16'h0001);
        send_item(KIND_LOOKUP, 32'h0000_0000, 6'd32, 16'h0000);
        send_item(KIND_INSERT, 32'h8000_0000, 6'd1, 16'h8000);
        send_item(KIND_LOOKUP, 32'h8000_0001, 6'd31, 16'h0000);
        send_item(KIND_LOOKUP, 32'h7FFF_FFFF, 6'd1, 16'h0000);

        // early part is insert heavy to fill the table, later part is lookup heavy
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_random(n < FILL_ITEMS);
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts and %0d lookups, incl. saturated lengths and overwrites;",
                 insert_items, lookup_items);
        $display("responses: %0d hits, %0d misses, %0d table-full rejects, %0d mismatches",
                 hit_total, miss_total, full_total, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Response side: quiet and choppy stretches, plus one long hold-off that backs
    // up the request channel.
    initial
    begin : receiver
        int   rsp_beats;
        int   hold_left;
        int   stall_left;
        int   rx_cycle;
        logic hold_done;
        logic choppy;
        rsp_ch.ready <= 1'b0;
        rsp_beats  = 0;
        hold_left  = 0;
        stall_left = 0;
        rx_cycle   = 0;
        hold_done  = 1'b0;
        choppy     = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rsp_ch.valid && rsp_ch.ready)
                rsp_beats++;
            if (rx_cycle % 512 == 0)
                choppy = 1'($urandom_range(0, 1));
            if (hold_left != 0)
                hold_left--;
            else if (!hold_done && rsp_beats >= HOLD_AFTER_BEATS)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall_left != 0)
                stall_left--;
            else if (choppy && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            rsp_ch.ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit with %0d responses outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> longest_prefix_match_table.f
+incdir+rtl
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_cell.sv
rtl/longest_prefix_match_table.sv
dv/lpm_table_checker.sv
dv/longest_prefix_match_table_tb.sv
